// ===== sv/fcca_pkg.sv =====
`timescale 1ns / 1ps

package fcca_pkg;

  // Entry layout: low bits are the link, upper bits are reserved
  localparam int unsigned LINK_W  = 28;
  localparam int unsigned RESV_W  = 4;
  localparam int unsigned ENTRY_W = LINK_W + RESV_W;
  localparam int unsigned LIMIT_W = 13;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned STAT_W  = 2;

  localparam int unsigned TABLE_DEPTH_DEF = 4096;

  localparam logic [LIMIT_W-1:0] CLUSTER_LIMIT_RST = 13'd4096;
  localparam logic [LINK_W-1:0]  END_OF_CHAIN_RST  = 28'hFFFFFF8;
  localparam logic [LINK_W-1:0]  FIRST_CLUSTER     = 28'd2;

  // Configuration register indexes
  localparam logic CFG_CLUSTER_LIMIT = 1'b0;
  localparam logic CFG_END_OF_CHAIN  = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_GET        = 3'd0,
    FN_SET        = 3'd1,
    FN_ALLOCATE   = 3'd2,
    FN_FREE       = 3'd3,
    FN_FREE_CHAIN = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NONE_FREE = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_BOUND     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_EVAL
  } state_e;

  // Configuration as seen by the sequencer
  typedef struct packed {
    logic [LIMIT_W-1:0] cluster_limit;
    logic [LINK_W-1:0]  end_of_chain;
  } cfg_t;

endpackage

// ===== sv/fcca_table.sv =====
`timescale 1ns / 1ps

module fcca_table import fcca_pkg::*; #(
  parameter int unsigned TableDepth = TABLE_DEPTH_DEF,
  parameter int unsigned AddrW      = $clog2(TableDepth)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   addr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem [TableDepth];
  logic [ENTRY_W-1:0] rdata_q;

  // Single port: write on enable, registered read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fcca_seq.sv =====
`timescale 1ns / 1ps

module fcca_seq import fcca_pkg::*; #(
  parameter int unsigned TableDepth = TABLE_DEPTH_DEF,
  parameter int unsigned AddrW      = $clog2(TableDepth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [LINK_W-1:0]  cluster_i,
  input  logic [LINK_W-1:0]  link_value_i,
  input  cfg_t               cfg_i,
  output logic               mem_we_o,
  output logic [AddrW-1:0]   mem_addr_o,
  output logic [ENTRY_W-1:0] mem_wdata_o,
  input  logic [ENTRY_W-1:0] mem_rdata_i,
  output logic               done_o,
  output logic [LINK_W-1:0]  result_cluster_o,
  output logic [STAT_W-1:0]  status_o
);

  localparam int unsigned StepW = $clog2(TableDepth + 1);
  localparam logic [LINK_W-1:0] DepthC   = LINK_W'(TableDepth);
  localparam logic [StepW-1:0]  DepthS   = StepW'(TableDepth);
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(TableDepth - 1);

  state_e             state_q, state_d;
  func_e              func_q, func_d;
  logic [LINK_W-1:0]  ptr_q, ptr_d;
  logic [LINK_W-1:0]  lv_q, lv_d;
  logic [StepW-1:0]   steps_q, steps_d;
  logic               done_q, done_d;
  logic [LINK_W-1:0]  res_q, res_d;
  status_e            stat_q, stat_d;

  logic               accept;
  logic [LINK_W-1:0]  ptr_inc;
  logic [LINK_W-1:0]  link;
  logic [RESV_W-1:0]  resv;
  logic               in_tab;
  logic               chk_done;
  status_e            chk_stat;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign ptr_inc = ptr_q + LINK_W'(1);
  assign link    = mem_rdata_i[LINK_W-1:0];
  assign resv    = mem_rdata_i[ENTRY_W-1:LINK_W];
  assign in_tab  = (ptr_q < DepthC);

  // Range and termination checks before each table access
  always_comb begin
    chk_done = 1'b0;
    chk_stat = STAT_OK;
    case (func_q)
      FN_GET, FN_SET, FN_FREE: begin
        chk_done = !in_tab;
        chk_stat = STAT_RANGE;
      end
      FN_ALLOCATE: begin
        chk_done = !(in_tab && (ptr_q < LINK_W'(cfg_i.cluster_limit)));
        chk_stat = STAT_NONE_FREE;
      end
      FN_FREE_CHAIN: begin
        if ((ptr_q < FIRST_CLUSTER) || (ptr_q >= cfg_i.end_of_chain)) begin
          chk_done = 1'b1;
          chk_stat = STAT_OK;
        end else if (!in_tab) begin
          chk_done = 1'b1;
          chk_stat = STAT_RANGE;
        end else if (steps_q >= DepthS) begin
          chk_done = 1'b1;
          chk_stat = STAT_BOUND;
        end
      end
      default: begin
        chk_done = 1'b1;
        chk_stat = STAT_OK;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (ptr_q[AddrW-1:0] == LastAddr) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = chk_done ? S_IDLE : S_READ;
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (func_q == FN_FREE_CHAIN ||
            (func_q == FN_ALLOCATE && link != '0)) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and table control
  always_comb begin
    func_d      = func_q;
    ptr_d       = ptr_q;
    lv_d        = lv_q;
    steps_d     = steps_q;
    done_d      = 1'b0;
    res_d       = res_q;
    stat_d      = stat_q;
    mem_we_o    = 1'b0;
    mem_wdata_o = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we_o = 1'b1;
        ptr_d    = ptr_inc;
      end
      S_IDLE: begin
        if (accept) begin
          func_d  = func_e'(func_i);
          ptr_d   = (func_e'(func_i) == FN_ALLOCATE) ? FIRST_CLUSTER : cluster_i;
          lv_d    = link_value_i;
          steps_d = '0;
        end
      end
      S_CHECK: begin
        if (chk_done) begin
          done_d = 1'b1;
          res_d  = '0;
          stat_d = chk_stat;
        end
      end
      S_EVAL: begin
        case (func_q)
          FN_GET: begin
            done_d = 1'b1;
            res_d  = link;
            stat_d = STAT_OK;
          end
          FN_SET: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = {resv, lv_q};
            done_d      = 1'b1;
            res_d       = '0;
            stat_d      = STAT_OK;
          end
          FN_FREE: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = {resv, {LINK_W{1'b0}}};
            done_d      = 1'b1;
            res_d       = '0;
            stat_d      = STAT_OK;
          end
          FN_ALLOCATE: begin
            if (link == '0) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = {resv, cfg_i.end_of_chain};
              done_d      = 1'b1;
              res_d       = ptr_q;
              stat_d      = STAT_OK;
            end else begin
              ptr_d = ptr_inc;
            end
          end
          FN_FREE_CHAIN: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = {resv, {LINK_W{1'b0}}};
            ptr_d       = link;
            steps_d     = steps_q + StepW'(1);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign mem_addr_o = ptr_q[AddrW-1:0];

  // Control state; reset starts the clearing sweep at entry zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      done_q  <= done_d;
    end
  end

  // Operands and result hold registers
  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    lv_q    <= lv_d;
    steps_q <= steps_d;
    res_q   <= res_d;
    stat_q  <= stat_d;
  end

  assign done_o           = done_q;
  assign result_cluster_o = res_q;
  assign status_o         = stat_q;

endmodule

// ===== sv/fat_cluster_chain_allocator_core.sv =====
`timescale 1ns / 1ps

// Channel   | Handshake           | Payload
// ----------+---------------------+------------------------------------------
// command   | start / busy        | func_i, cluster_i, link_value_i
// result    | done_o (strobe)     | result_cluster_o, status_o
// config    | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// A command is taken when start is high and busy is low; the result strobes
// for one cycle and must be taken then. Each table access passes the check,
// read and evaluate states on the single table port. Out-of-range commands
// end in the check state; allocate scans one entry per pass and ends in a
// failing check if none is free; free chain clears a link per pass up to a
// final check. After reset the table is cleared one entry a cycle, busy high.

module fat_cluster_chain_allocator_core import fcca_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [LINK_W-1:0] cluster_i,
  input  logic [LINK_W-1:0] link_value_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [LINK_W-1:0] cfg_data_i,
  output logic              done_o,
  output logic [LINK_W-1:0] result_cluster_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  cfg_t               cfg_q;
  logic               mem_we;
  logic [AddrW-1:0]   mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cluster_limit <= CLUSTER_LIMIT_RST;
      cfg_q.end_of_chain  <= END_OF_CHAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLUSTER_LIMIT: cfg_q.cluster_limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_END_OF_CHAIN:  cfg_q.end_of_chain  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fcca_seq #(
    .TableDepth (TABLE_DEPTH),
    .AddrW      (AddrW)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .cluster_i        (cluster_i),
    .link_value_i     (link_value_i),
    .cfg_i            (cfg_q),
    .mem_we_o         (mem_we),
    .mem_addr_o       (mem_addr),
    .mem_wdata_o      (mem_wdata),
    .mem_rdata_i      (mem_rdata),
    .done_o           (done_o),
    .result_cluster_o (result_cluster_o),
    .status_o         (status_o)
  );

  fcca_table #(
    .TableDepth (TABLE_DEPTH),
    .AddrW      (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== sv/fcca_checker.sv =====
`timescale 1ns / 1ps

module fcca_checker import fcca_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input logic [LINK_W-1:0] result_cluster_o,
  input logic [STAT_W-1:0] status_o
);

  // An accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // No result directly after an accept
  a_accept_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result strobe one cycle after accept");

  // A result is only shown once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Failed transactions return a zero cluster
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_NONE_FREE || status_o == STAT_RANGE ||
                status_o == STAT_BOUND)) |-> (result_cluster_o == '0))
    else $error("nonzero cluster with failing status");

endmodule

bind fat_cluster_chain_allocator_core fcca_checker u_fcca_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .result_cluster_o (result_cluster_o),
  .status_o         (status_o)
);
